@@ hdl/insertion_sorter_with_compare_count_macros.svh @@
// Assertion macros shared by the verification files of the insertion sorter.
// Included by the checker module; depends on nothing else.
`ifndef INSERTION_SORTER_WITH_COMPARE_COUNT_MACROS_SVH
`define INSERTION_SORTER_WITH_COMPARE_COUNT_MACROS_SVH

// Same-cycle implication: whenever the antecedent holds, the consequent must follow.
`define ISCC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
    else $error(msg);

// Next-cycle implication: the consequent must hold in the cycle after the antecedent.
`define ISCC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/iscc_pkg.sv @@
// Package for the insertion sorter: widths, request and result types, sequencer states.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package iscc_pkg;

  localparam int DATA_W        = 32;
  localparam int CNT_W         = 12;
  localparam int MAX_ITEMS_DEF = 64;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last_item;
  } iscc_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic [CNT_W-1:0]         compare_count;
    logic                     overflowed;
    logic                     last_result;
  } iscc_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } iscc_state_t;

endpackage

@@ hdl/iscc_store.sv @@
// Sorted value store: a single-port-write, single-port-read memory with registered read data.
// Depends on iscc_pkg for the data width.
`timescale 1ns / 1ps

module iscc_store
  import iscc_pkg::*;
#(
  parameter int DEPTH = MAX_ITEMS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  logic signed [DATA_W-1:0] wdata,
  input  logic [AW-1:0]            raddr,
  output logic signed [DATA_W-1:0] rdata
);

  logic signed [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/iscc_ctrl.sv @@
// Sequencer of the insertion sorter: walks the store downwards with one shared signed
// comparator, then reads the store out in order. Depends on iscc_pkg.
`timescale 1ns / 1ps

module iscc_ctrl
  import iscc_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF,
  parameter int AW        = $clog2(MAX_ITEMS),
  parameter int CW        = $clog2(MAX_ITEMS + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  iscc_in_t                 item,
  output logic                     busy,
  output logic                     mem_we,
  output logic [AW-1:0]            mem_waddr,
  output logic signed [DATA_W-1:0] mem_wdata,
  output logic [AW-1:0]            mem_raddr,
  input  logic signed [DATA_W-1:0] mem_rdata,
  output logic                     result_valid,
  output iscc_out_t                result
);

  localparam logic [CW-1:0] FULL = CW'(MAX_ITEMS);

  iscc_state_t state, state_next;

  logic signed [DATA_W-1:0] val, val_next;
  logic                     last, last_next;
  logic [CW-1:0]            pos, pos_next;
  logic [CW-1:0]            k, k_next;
  logic [CW-1:0]            fill, fill_next;
  logic [CNT_W-1:0]         total, total_next;
  logic                     ovf, ovf_next;

  logic greater;
  logic is_final;
  logic [CNT_W-1:0] total_inc;

  // The one shared comparator: stored entry against the value being inserted.
  assign greater   = mem_rdata > val;
  assign is_final  = (k + CW'(1)) == fill;
  assign total_inc = (total == CNT_MAX) ? total : total + CNT_W'(1);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (fill == FULL) begin
            state_next = item.last_item ? ST_EMIT_RD : ST_IDLE;
          end else begin
            state_next = ST_INS_RD;
          end
        end
      end
      ST_INS_RD: begin
        if (pos == '0) begin
          state_next = last ? ST_EMIT_RD : ST_IDLE;
        end else begin
          state_next = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        if (greater) begin
          state_next = ST_INS_RD;
        end else begin
          state_next = last ? ST_EMIT_RD : ST_IDLE;
        end
      end
      ST_EMIT_RD:  state_next = ST_EMIT_OUT;
      ST_EMIT_OUT: state_next = is_final ? ST_IDLE : ST_EMIT_RD;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Outputs towards the store and the result port.
  always_comb begin
    busy                 = (state != ST_IDLE);
    mem_we               = 1'b0;
    mem_waddr            = pos[AW-1:0];
    mem_wdata            = val;
    mem_raddr            = AW'(pos - CW'(1));
    result_valid         = 1'b0;
    result.sorted_value  = mem_rdata;
    result.compare_count = total;
    result.overflowed    = ovf;
    result.last_result   = is_final;
    unique case (state)
      ST_IDLE: ;
      ST_INS_RD: begin
        mem_we = (pos == '0);
      end
      ST_INS_CMP: begin
        mem_we    = 1'b1;
        mem_wdata = greater ? mem_rdata : val;
      end
      ST_EMIT_RD: begin
        mem_raddr = k[AW-1:0];
      end
      ST_EMIT_OUT: begin
        result_valid = 1'b1;
      end
      default: ;
    endcase
  end

  // Datapath registers.
  always_comb begin
    val_next   = val;
    last_next  = last;
    pos_next   = pos;
    k_next     = k;
    fill_next  = fill;
    total_next = total;
    ovf_next   = ovf;
    unique case (state)
      ST_IDLE: begin
        k_next = '0;
        if (start) begin
          val_next  = item.value;
          last_next = item.last_item;
          pos_next  = fill;
          if (fill == FULL) begin
            ovf_next = 1'b1;
          end
        end
      end
      ST_INS_RD: begin
        if (pos == '0) begin
          // Landed at the bottom of the store; only the very first value is free.
          fill_next = fill + CW'(1);
          if (fill != '0) begin
            total_next = total_inc;
          end
        end
      end
      ST_INS_CMP: begin
        total_next = total_inc;
        if (greater) begin
          pos_next = pos - CW'(1);
        end else begin
          fill_next = fill + CW'(1);
        end
      end
      ST_EMIT_RD: ;
      ST_EMIT_OUT: begin
        k_next = k + CW'(1);
        if (is_final) begin
          fill_next  = '0;
          total_next = '0;
          ovf_next   = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fill  <= '0;
      total <= '0;
      ovf   <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      total <= total_next;
      ovf   <= ovf_next;
    end
  end

  always_ff @(posedge clk) begin
    val  <= val_next;
    last <= last_next;
    pos  <= pos_next;
    k    <= k_next;
  end

endmodule

@@ hdl/insertion_sorter_with_compare_count.sv @@
// Top level of the insertion sorter with comparison count.
// Instantiates iscc_ctrl and iscc_store; depends on iscc_pkg.
`timescale 1ns / 1ps
//
// Usage
//   A request is taken at a rising edge where start is high and busy is low. Its item
//   carries one signed 32-bit value and a last_item mark. The value is inserted into an
//   ascending store exactly as straight insertion sort would, equal values keeping
//   their arrival order.
//   Insertion walks down the store one entry at a time through the single memory read
//   port and one signed comparator: every stored value greater than the new one is
//   read, then compared and moved up, and the value is then placed in the free entry.
//   When the store already holds MAX_ITEMS values, the new value is dropped and the
//   overflowed flag is raised for the rest of the set.
//   On a request marked last the whole set is read out in ascending order; each
//   result is read from the store and then shown on result for exactly one cycle with
//   result_valid high. Every result carries the set's comparison total and overflow
//   flag, and the final one has last_result set. The receiver cannot stall the block.
//   After the final result the store, the count and the flag clear and busy falls.
//   A synchronous reset returns the sequencer to idle with an empty store; the
//   memory itself is not cleared, since only entries below the fill count are read.
//
module insertion_sorter_with_compare_count
  import iscc_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  iscc_in_t  item,
  output logic      busy,
  output logic      result_valid,
  output iscc_out_t result
);

  // The address covers the store; the fill count must also be able to hold MAX_ITEMS.
  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);

  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic signed [DATA_W-1:0] mem_wdata;
  logic [AW-1:0]            mem_raddr;
  logic signed [DATA_W-1:0] mem_rdata;

  // Sequencer with the shared comparator and all counters.
  iscc_ctrl #(
    .MAX_ITEMS (MAX_ITEMS),
    .AW        (AW),
    .CW        (CW)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .item         (item),
    .busy         (busy),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata),
    .result_valid (result_valid),
    .result       (result)
  );

  // The sorted values live in a plain memory with a registered read.
  iscc_store #(
    .DEPTH (MAX_ITEMS),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

@@ hdl/iscc_checker.sv @@
// Port-level checker for the insertion sorter, bound to the top level.
// Depends on iscc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "insertion_sorter_with_compare_count_macros.svh"

module iscc_checker
  import iscc_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      start,
  input iscc_in_t  item,
  input logic      busy,
  input logic      result_valid,
  input iscc_out_t result
);

  `ISCC_ASSERT_IMPL(a_result_while_busy, clk, rst, result_valid, busy, "result outside a busy period")
  `ISCC_ASSERT_NEXT(a_result_spacing, clk, rst, result_valid, !result_valid, "results back to back")
  `ISCC_ASSERT_NEXT(a_idle_after_final, clk, rst, result_valid && result.last_result, !busy, "still busy after final result")
  `ISCC_ASSERT_NEXT(a_no_result_mid_set, clk, rst, start && !busy && !item.last_item, !result_valid, "result after a request not marked last")
  `ISCC_ASSERT_IMPL(a_count_steady, clk, rst, result_valid && !result.last_result, ##2 (result_valid && result.compare_count == $past(result.compare_count, 2)), "comparison total changed within a set")

endmodule

bind insertion_sorter_with_compare_count iscc_checker u_iscc_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .item         (item),
  .busy         (busy),
  .result_valid (result_valid),
  .result       (result)
);
